### rtl/core/rnct_pkg.sv
// ----------------------------------------------------------------------------
// rnct_pkg
// Shared types and constants of the node48 child table.
// ----------------------------------------------------------------------------
package rnct_pkg;

    localparam int KEYS       = 256;
    localparam int KEY_W      = 8;
    localparam int MODE_W     = 3;
    localparam int THR_W      = 6;
    localparam logic [THR_W-1:0] THR_RESET = 6'd12;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHANGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RANGE   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GSMALL  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RDIDX,
        ST_RDCH,
        ST_EXEC,
        ST_PUSH
    } state_t;

    // key-bit scan result
    typedef struct packed {
        logic [KEY_W-1:0] pred_key;
        logic             has_smaller;
        logic             has_bigger;
    } scan_res_t;

endpackage

### rtl/core/rnct_ram.sv
// ----------------------------------------------------------------------------
// rnct_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rnct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rnct_scan.sv
// ----------------------------------------------------------------------------
// rnct_scan
// Priority encoders over the 256 live-key bits: nearest live key below the
// given key, and whether live keys exist below and above it. Registered.
// ----------------------------------------------------------------------------
module rnct_scan
    import rnct_pkg::*;
(
    input  logic             aclk,
    input  logic             load,
    input  logic [KEYS-1:0]  live_keys,
    input  logic [KEY_W-1:0] key,
    output scan_res_t        res
);

    scan_res_t       res_reg;
    scan_res_t       res_next;
    logic [KEYS-1:0] below;
    logic [KEYS-1:0] above;

    // masks and highest live key below
    always_comb begin
        below = live_keys & ((KEYS'(1) << key) - KEYS'(1));
        above = (live_keys >> key) >> 1;
        res_next.pred_key = '0;
        for (int i = 0; i < KEYS; i++) begin
            if (below[i]) begin
                res_next.pred_key = KEY_W'(i);
            end
        end
        res_next.has_smaller = |below;
        res_next.has_bigger  = |above;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/radix_node48_child_table_core.sv
// ----------------------------------------------------------------------------
// radix_node48_child_table_core
// Child table of a 48-way radix index node: key-byte index to child slots.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An accepted transaction passes a scan
// step (priority encoders over the 256 live-key bits and the slot flags), an
// index RAM read, a child RAM read and an execute/write-back step, and then
// enters the output register once that register is free. A new transaction is
// taken only after the last result has entered the output register. The
// output register lets the next transaction start while a result waits. No
// clearing pass is needed after reset: per-key presence and per-slot flags are
// flip-flops cleared by reset. shrink_threshold is written through cfg_wr_en.
module radix_node48_child_table_core
    import rnct_pkg::*;
#(
    parameter int SLOTS       = 48,
    parameter int HANDLE_BITS = 48
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [THR_W-1:0]                      cfg_wr_data,   // shrink_threshold
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // mode[2:0], key, child_in, force_req, zero pad
    input  logic [((HANDLE_BITS+12+7)/8)*8-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // ok, found, child_out, has_smaller, has_bigger, zero pad
    output logic [((HANDLE_BITS+4+7)/8)*8-1:0]    m_tdata
);

    localparam int OUT_W = ((HANDLE_BITS + 4 + 7) / 8) * 8;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int H     = HANDLE_BITS;

    // control and state
    state_t            state_reg, state_next;
    logic [THR_W-1:0]  thr_reg;
    logic [CW-1:0]     count_reg;
    logic [KEYS-1:0]   present_reg;
    logic [KEYS-1:0]   live_reg;
    logic [SLOTS-1:0]  used_reg;
    logic [SLOTS-1:0]  nz_reg;
    logic [SLOTS-1:0]  leaf_reg;

    // latched transaction
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [H-1:0]      child_reg;
    logic              force_reg;

    // per-item working registers
    logic [SW-1:0]     free_slot_reg, free_slot_next;
    logic [SW-1:0]     fb_slot_reg, fb_slot_next;
    logic              fb_valid_reg, fb_valid_next;
    logic [SW-1:0]     tgt_reg, tgt_next;
    logic              use_pred_reg, use_pred_next;
    logic [OUT_W-1:0]  res_reg, res_next;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    scan_res_t         scan;
    logic              accept;
    logic              scan_load;
    logic [KEY_W-1:0]  idx_raddr;
    logic [SW-1:0]     slot_rd;
    logic [H-1:0]      ch_rd;
    logic [H-1:0]      cval;
    logic              present;

    // execute decisions
    logic              wr_child;
    logic              new_key;
    logic              del_key;
    logic              ok;
    logic              found;
    logic [H-1:0]      child_out;
    logic              hs;
    logic              hb;
    logic              refuse;

    assign accept  = s_tvalid && s_tready;
    assign present = present_reg[key_reg];

    // key-bit encoders
    rnct_scan u_scan (
        .aclk      (aclk),
        .load      (scan_load),
        .live_keys (live_reg),
        .key       (key_reg),
        .res       (scan)
    );

    // index store: key -> slot
    rnct_ram #(.WIDTH(SW), .DEPTH(KEYS)) u_idx_ram (
        .aclk  (aclk),
        .we    (new_key),
        .waddr (key_reg),
        .wdata (free_slot_reg),
        .raddr (idx_raddr),
        .rdata (slot_rd)
    );

    // child handle store
    rnct_ram #(.WIDTH(H), .DEPTH(SLOTS)) u_child_ram (
        .aclk  (aclk),
        .we    (wr_child),
        .waddr (tgt_reg),
        .wdata (child_reg),
        .raddr (tgt_next),
        .rdata (ch_rd)
    );

    // slot encoders: lowest free, lowest leaf else highest non-null
    always_comb begin
        logic [SW-1:0] leaf_slot;
        logic [SW-1:0] hi_slot;
        logic          any_leaf;
        free_slot_next = '0;
        leaf_slot      = '0;
        hi_slot        = '0;
        any_leaf       = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_slot_next = SW'(i);
            end
            if (nz_reg[i] && leaf_reg[i]) begin
                leaf_slot = SW'(i);
                any_leaf  = 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (nz_reg[i]) begin
                hi_slot = SW'(i);
            end
        end
        fb_slot_next  = any_leaf ? leaf_slot : hi_slot;
        fb_valid_next = |nz_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SCAN;
            ST_SCAN:  state_next = ST_RDIDX;
            ST_RDIDX: state_next = ST_RDCH;
            ST_RDCH:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_PUSH;
            ST_PUSH: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        scan_load = (state_reg == ST_SCAN);
        idx_raddr = key_reg;
        if (state_reg == ST_RDIDX && (mode_reg == MODE_RANGE || mode_reg == MODE_GSMALL)) begin
            idx_raddr = scan.pred_key;
        end
        tgt_next      = tgt_reg;
        use_pred_next = use_pred_reg;
        if (state_reg == ST_RDCH) begin
            case (mode_reg)
                MODE_RANGE: begin
                    tgt_next      = slot_rd;
                    use_pred_next = scan.has_smaller;
                end
                MODE_GSMALL: begin
                    use_pred_next = scan.has_smaller && (count_reg != CW'(1));
                    tgt_next      = use_pred_next ? slot_rd : fb_slot_reg;
                end
                default: begin
                    tgt_next      = present ? slot_rd : free_slot_reg;
                    use_pred_next = 1'b0;
                end
            endcase
        end
    end

    // execute: result and write-back decisions
    always_comb begin
        cval      = nz_reg[tgt_reg] ? ch_rd : '0;
        refuse    = (THR_W'(count_reg) <= thr_reg) && !force_reg;
        wr_child  = 1'b0;
        new_key   = 1'b0;
        del_key   = 1'b0;
        ok        = 1'b0;
        found     = 1'b0;
        child_out = '0;
        hs        = 1'b0;
        hb        = 1'b0;
        if (state_reg == ST_EXEC) begin
            case (mode_reg)
                MODE_LOOKUP: begin
                    ok        = 1'b1;
                    child_out = present ? cval : '0;
                end
                MODE_INSERT: begin
                    if (present) begin
                        wr_child = 1'b1;
                        ok       = 1'b1;
                    end else if (count_reg < CW'(SLOTS)) begin
                        wr_child = 1'b1;
                        new_key  = 1'b1;
                        ok       = 1'b1;
                    end
                end
                MODE_CHANGE: begin
                    wr_child = present;
                    ok       = present;
                end
                MODE_REMOVE: begin
                    ok      = !refuse;
                    del_key = !refuse && present;
                end
                MODE_RANGE: begin
                    ok        = 1'b1;
                    hs        = scan.has_smaller;
                    hb        = scan.has_bigger;
                    child_out = hs ? cval : '0;
                end
                MODE_GSMALL: begin
                    ok = 1'b1;
                    if (use_pred_reg || fb_valid_reg) begin
                        child_out = cval;
                    end
                end
                default: ;
            endcase
            found = (child_out != '0);
        end
        res_next = '0;
        res_next[0]       = ok;
        res_next[1]       = found;
        res_next[H+1:2]   = child_out;
        res_next[H+2]     = hs;
        res_next[H+3]     = hb;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            count_reg    <= '0;
            present_reg  <= '0;
            live_reg     <= '0;
            used_reg     <= '0;
            nz_reg       <= '0;
            leaf_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            // child written: refresh slot and key flags
            if (wr_child) begin
                nz_reg[tgt_reg]   <= (child_reg != '0);
                leaf_reg[tgt_reg] <= child_reg[H-1];
                live_reg[key_reg] <= (child_reg != '0);
            end
            if (new_key) begin
                present_reg[key_reg] <= 1'b1;
                used_reg[tgt_reg]    <= 1'b1;
                count_reg            <= count_reg + CW'(1);
            end
            if (del_key) begin
                present_reg[key_reg] <= 1'b0;
                live_reg[key_reg]    <= 1'b0;
                used_reg[tgt_reg]    <= 1'b0;
                nz_reg[tgt_reg]      <= 1'b0;
                leaf_reg[tgt_reg]    <= 1'b0;
                count_reg            <= count_reg - CW'(1);
            end
            // output register
            if (state_reg == ST_PUSH && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg  <= s_tdata[MODE_W-1:0];
            key_reg   <= s_tdata[MODE_W+KEY_W-1:MODE_W];
            child_reg <= s_tdata[H+10:11];
            force_reg <= s_tdata[H+11];
        end
        if (state_reg == ST_SCAN) begin
            free_slot_reg <= free_slot_next;
            fb_slot_reg   <= fb_slot_next;
            fb_valid_reg  <= fb_valid_next;
        end
        tgt_reg      <= tgt_next;
        use_pred_reg <= use_pred_next;
        if (state_reg == ST_EXEC) begin
            res_reg <= res_next;
        end
        if (state_reg == ST_PUSH && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/core/rnct_check.sv
// ----------------------------------------------------------------------------
// rnct_check
// Port-level checks of the node48 child table, bound to the top level.
// ----------------------------------------------------------------------------
module rnct_check #(
    parameter int HANDLE_BITS = 48
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((HANDLE_BITS+4+7)/8)*8-1:0]  m_tdata
);

    localparam int H = HANDLE_BITS;

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction in flight
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // found tracks a non-null child
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1] == (m_tdata[H+1:2] != '0)))
        else $error("found disagrees with child_out");

    // smaller key implies found and ok
    a_hs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[H+2] |-> m_tdata[1] && m_tdata[0])
        else $error("has_smaller without found");

endmodule

bind radix_node48_child_table_core rnct_check #(.HANDLE_BITS(HANDLE_BITS)) u_rnct_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
